// ===== design/top_k_sorted_insert_table_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TOP_K_SORTED_INSERT_TABLE_MACROS_SVH
`define TOP_K_SORTED_INSERT_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKSIT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("top-k table check failed");

// The consequent must hold in the cycle after the antecedent.
`define TKSIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("top-k table check failed");

`endif

// ===== design/tksit_pkg.sv =====
`default_nettype none
package tksit_pkg;

	localparam int TABLE_DEPTH = 10;
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

	localparam int INDEX_W = 4;
	localparam int TAG_W   = 24;
	localparam int SCORE_W = 32;
	localparam int RATE_W  = 16;
	localparam int RANK_W  = 4;
	localparam int FILL_W  = 4;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 88;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} tksit_op_t;

	typedef struct packed {
		logic               valid;
		logic [SCORE_W-1:0] score;
		logic [RATE_W-1:0]  rate;
		logic [TAG_W-1:0]   tag;
	} tksit_entry_t;

	typedef struct packed {
		logic         wr;
		tksit_entry_t rec;
	} tksit_ins_t;

	// Every byte after the first zero byte becomes zero.
	function automatic logic [TAG_W-1:0] clean_tag(input logic [TAG_W-1:0] raw);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		b0 = raw[7:0];
		b1 = raw[15:8];
		b2 = raw[23:16];
		if (b0 == 8'd0) begin
			b1 = 8'd0;
			b2 = 8'd0;
		end
		if (b1 == 8'd0) begin
			b2 = 8'd0;
		end
		return {b2, b1, b0};
	endfunction

endpackage
`default_nettype wire

// ===== design/tksit_cell.sv =====
`default_nettype none
module tksit_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tksit_pkg::tksit_ins_t   ctl,
	input  tksit_pkg::tksit_entry_t prev,
	input  wire                     prev_take,
	output tksit_pkg::tksit_entry_t ent,
	output logic                    take
);

	tksit_pkg::tksit_entry_t ent_q;
	logic                    hit;

	// An empty slot or a strictly lower score claims the new record.
	assign hit  = !ent_q.valid || (ctl.rec.score > ent_q.score);
	assign take = prev_take || hit;
	assign ent  = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.wr && take) begin
			if (prev_take) begin
				ent_q <= prev;
			end else begin
				ent_q <= ctl.rec;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/top_k_sorted_insert_table.sv =====
// Channel   Dir  Fields (low bit first)
// s_axis    in   tuser: op; tdata: index, tag_bytes, score, rate
// m_axis    out  tdata: placed, rank, filled, entry_valid, entry_tag, entry_score, entry_rate
//
// The row of cells compares and shifts in the cycle of acceptance.
// The result sits in an output register, so a new word is taken whenever that register
// is empty or being emptied in the same cycle.
// A stalled output holds s_tready low until the result is taken.
// Reset empties every cell and the output register.
`default_nettype none
module top_k_sorted_insert_table (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [tksit_pkg::S_TDATA_W-1:0]    s_tdata,  // index, tag_bytes, score, rate, pad
	input  wire                                s_tuser,  // op
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [tksit_pkg::M_TDATA_W-1:0]    m_tdata   // placed, rank, filled,
	                                                     // entry_valid, entry_tag, entry_score,
	                                                     // entry_rate, pad
);

	localparam int D = tksit_pkg::TABLE_DEPTH;

	logic                                accept;
	tksit_pkg::tksit_op_t                op;
	logic [tksit_pkg::INDEX_W-1:0]       rd_index;
	tksit_pkg::tksit_ins_t               ctl;
	tksit_pkg::tksit_entry_t             ent [D];
	logic [D:0]                          take_chain;
	logic [tksit_pkg::COUNT_W-1:0]       count_q;
	logic [tksit_pkg::COUNT_W-1:0]       count_next;
	logic                                placed;
	logic [tksit_pkg::RANK_W-1:0]        rank;
	tksit_pkg::tksit_entry_t             rd_ent;
	logic                                m_tvalid_q;
	logic [tksit_pkg::M_TDATA_W-1:0]     m_tdata_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = tksit_pkg::tksit_op_t'(s_tuser);
	assign rd_index = s_tdata[3:0];

	assign ctl.wr        = accept && (op == tksit_pkg::OP_INSERT);
	assign ctl.rec.valid = 1'b1;
	assign ctl.rec.tag   = tksit_pkg::clean_tag(s_tdata[27:4]);
	assign ctl.rec.score = s_tdata[59:28];
	assign ctl.rec.rate  = s_tdata[75:60];

	assign take_chain[0] = 1'b0;

	for (genvar i = 0; i < D; i++) begin : g_cell
		if (i == 0) begin : g_head
			tksit_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prev      ('0),
				.prev_take (take_chain[0]),
				.ent       (ent[0]),
				.take      (take_chain[1])
			);
		end else begin : g_body
			tksit_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prev      (ent[i-1]),
				.prev_take (take_chain[i]),
				.ent       (ent[i]),
				.take      (take_chain[i+1])
			);
		end
	end

	assign placed = (op == tksit_pkg::OP_INSERT) && take_chain[D];

	always_comb begin
		rank = '0;
		for (int i = 0; i < D; i++) begin
			if (take_chain[i+1] && !take_chain[i]) begin
				rank = rank | tksit_pkg::RANK_W'(i);
			end
		end
	end

	always_comb begin
		rd_ent = '0;
		for (int i = 0; i < D; i++) begin
			if ((int'(rd_index) == i) && ent[i].valid) begin
				rd_ent = ent[i];
			end
		end
		if (op != tksit_pkg::OP_READ) begin
			rd_ent = '0;
		end
	end

	always_comb begin
		count_next = count_q;
		if (placed && (int'(count_q) < D)) begin
			count_next = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.wr) begin
				count_q <= count_next;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {6'd0,
				rd_ent.rate,
				rd_ent.score,
				rd_ent.tag,
				rd_ent.valid,
				tksit_pkg::FILL_W'(count_next),
				placed ? rank : {tksit_pkg::RANK_W{1'b0}},
				placed};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ===== design/tksit_checker.sv =====
`default_nettype none
`include "top_k_sorted_insert_table_macros.svh"
module tksit_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tready,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [tksit_pkg::M_TDATA_W-1:0]  m_tdata
);

	`TKSIT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`TKSIT_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
	`TKSIT_ASSERT_NOW(a_insert_no_entry, m_tvalid && m_tdata[0], m_tdata[81:9] == '0)
	`TKSIT_ASSERT_NOW(a_filled_bound, m_tvalid, int'(m_tdata[8:5]) <= tksit_pkg::TABLE_DEPTH)
	`TKSIT_ASSERT_NOW(a_rank_below_filled, m_tvalid && m_tdata[0], m_tdata[4:1] < m_tdata[8:5])

endmodule

bind top_k_sorted_insert_table tksit_checker u_tksit_checker (.*);
`default_nettype wire

// ===== sim/tb_top_k_sorted_insert_table.sv =====
`default_nettype none
module tb_top_k_sorted_insert_table;
	import tksit_pkg::*;

	localparam int DEPTH = TABLE_DEPTH;
	localparam int WORDS_PER_PHASE = 430;

	typedef struct packed {
		bit              placed;
		bit [RANK_W-1:0] rank;
		bit [FILL_W-1:0] filled;
		bit              entry_valid;
		bit [TAG_W-1:0]  tag;
		bit [SCORE_W-1:0] score;
		bit [RATE_W-1:0] rate;
	} table_result_t;

	// Tracks the expected contents of the ranked table and the results still owed.
	class top_k_ledger;
		bit [SCORE_W-1:0] scores[DEPTH];
		bit [RATE_W-1:0]  rates[DEPTH];
		bit [TAG_W-1:0]   tags[DEPTH];
		int               count;
		table_result_t    expected_results[$];
		int               mismatches;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				scores[i] = '0;
				rates[i]  = '0;
				tags[i]   = '0;
			end
			count = 0;
			mismatches = 0;
		endfunction

		function bit [TAG_W-1:0] tidy_tag(bit [TAG_W-1:0] raw);
			bit seen_zero;
			bit [TAG_W-1:0] kept;
			seen_zero = 0;
			kept = '0;
			for (int b = 0; b < 3; b++) begin
				if (raw[8*b +: 8] == 8'd0)
					seen_zero = 1;
				if (!seen_zero)
					kept[8*b +: 8] = raw[8*b +: 8];
			end
			return kept;
		endfunction

		function void note_word(tksit_op_t op, bit [INDEX_W-1:0] idx, bit [TAG_W-1:0] tag,
		                        bit [SCORE_W-1:0] score, bit [RATE_W-1:0] rate);
			table_result_t r;
			int slot;
			int last;
			r = '0;
			if (op == OP_INSERT) begin
				slot = count;
				for (int i = 0; i < count; i++) begin
					if (score > scores[i]) begin
						slot = i;
						break;
					end
				end
				if (slot < DEPTH) begin
					last = (count < DEPTH) ? count : DEPTH - 1;
					for (int i = last; i > slot; i--) begin
						scores[i] = scores[i-1];
						rates[i]  = rates[i-1];
						tags[i]   = tags[i-1];
					end
					scores[slot] = score;
					rates[slot]  = rate;
					tags[slot]   = tidy_tag(tag);
					if (count < DEPTH)
						count++;
					r.placed = 1;
					r.rank   = RANK_W'(slot);
				end
			end else if (idx < count) begin
				r.entry_valid = 1;
				r.tag   = tags[idx];
				r.score = scores[idx];
				r.rate  = rates[idx];
			end
			r.filled = FILL_W'(count);
			expected_results.push_back(r);
		endfunction

		function void check_word(bit [M_TDATA_W-1:0] w);
			table_result_t got;
			table_result_t want;
			got.placed      = w[0];
			got.rank        = w[4:1];
			got.filled      = w[8:5];
			got.entry_valid = w[9];
			got.tag         = w[33:10];
			got.score       = w[65:34];
			got.rate        = w[81:66];
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word %h with nothing pending.", w);
				return;
			end
			want = expected_results.pop_front();
			if (got.placed != want.placed || got.rank != want.rank ||
			    got.filled != want.filled || got.entry_valid != want.entry_valid ||
			    got.tag != want.tag || got.score != want.score || got.rate != want.rate) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Mismatch exp: p=%0d r=%0d f=%0d v=%0d tag=%h sc=%h rt=%h",
					         want.placed, want.rank, want.filled, want.entry_valid,
					         want.tag, want.score, want.rate);
					$display("         got: p=%0d r=%0d f=%0d v=%0d tag=%h sc=%h rt=%h",
					         got.placed, got.rank, got.filled, got.entry_valid,
					         got.tag, got.score, got.rate);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	top_k_ledger ledger;

	top_k_sorted_insert_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_word(m_tdata);
	end

	task automatic send_word(tksit_op_t op, bit [INDEX_W-1:0] idx, bit [TAG_W-1:0] tag,
	                         bit [SCORE_W-1:0] score, bit [RATE_W-1:0] rate);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, rate, score, tag, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ledger.note_word(op, idx, tag, score, rate);
	endtask

	task automatic send_random_word();
		bit [TAG_W-1:0] tag;
		bit [SCORE_W-1:0] score;
		bit [SCORE_W-1:0] near;
		int unsigned pick;
		tag = TAG_W'($urandom_range(24'hFFFFFF));
		if ($urandom_range(3) == 0)
			tag[8*$urandom_range(2) +: 8] = 8'd0;
		if ($urandom_range(99) < 30) begin
			send_word(OP_READ, INDEX_W'($urandom_range(15)), tag, $urandom,
			          RATE_W'($urandom_range(16'hFFFF)));
			return;
		end
		near = (ledger.count == 0) ? $urandom : ledger.scores[$urandom_range(ledger.count - 1)];
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2: score = $urandom;
			3, 4:    score = near;
			5, 6:    score = near + 1;
			7:       score = near - 1;
			8:       score = '0;
			default: score = '1;
		endcase
		send_word(OP_INSERT, INDEX_W'($urandom_range(15)), tag, score,
		          RATE_W'($urandom_range(16'hFFFF)));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (ledger.expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		ledger = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_READ, 4'd0, 24'h414243, 32'h0, 16'h0);
		send_word(OP_READ, 4'd15, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send_word(OP_INSERT, 4'd15, 24'hFFFFFF, 32'h0, 16'hFFFF);
		send_word(OP_INSERT, 4'd0, 24'h434200, 32'hFFFFFFFF, 16'h0);
		send_word(OP_INSERT, 4'd3, 24'h430041, 32'd100, 16'h1234);
		send_word(OP_INSERT, 4'd0, 24'h434241, 32'd100, 16'h0001);
		send_word(OP_INSERT, 4'd0, 24'h004241, 32'd100, 16'h0002);
		send_word(OP_INSERT, 4'd0, 24'h7A7A7A, 32'd50, 16'h8000);
		send_word(OP_INSERT, 4'd0, 24'h313233, 32'd200, 16'h7FFF);
		send_word(OP_INSERT, 4'd0, 24'h000000, 32'd7, 16'h00FF);
		send_word(OP_INSERT, 4'd0, 24'h202020, 32'd3, 16'hFF00);
		send_word(OP_INSERT, 4'd0, 24'h616263, 32'd1000, 16'hAAAA);
		send_word(OP_INSERT, 4'd0, 24'h414141, 32'h0, 16'h5555);
		send_word(OP_INSERT, 4'd0, 24'h424242, 32'd1, 16'h5555);
		send_word(OP_INSERT, 4'd0, 24'h434343, 32'hFFFFFFFF, 16'hFFFF);
		send_word(OP_READ, 4'd0, 24'h0, 32'h0, 16'h0);
		send_word(OP_READ, 4'd1, 24'h0, 32'h0, 16'h0);
		send_word(OP_READ, 4'd9, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send_word(OP_READ, 4'd10, 24'h0, 32'h0, 16'h0);
		send_word(OP_READ, 4'd15, 24'h0, 32'h0, 16'h0);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 20;
					recv_stall_pct = 64;
				end
				1: begin
					send_idle_pct  = 64;
					recv_stall_pct = 20;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_random_word();
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
